@@ rtl/ook_rsfs_pkg.sv @@
// types and constants for the ook remote switch frame sender
// no dependencies; imported by ook_remote_switch_frame_sender
`timescale 1ns / 1ps

package ook_rsfs_pkg;

    localparam int ID_FIELD_W   = 26;
    localparam int UNIT_FIELD_W = 4;
    localparam int RC_W         = 8;
    localparam int DUR_W        = 16;
    localparam int TIME_W       = 12;
    localparam int PERIOD_W     = 10;
    localparam int CFG_IDX_W    = 2;

    localparam logic [DUR_W-1:0] SYNC_GAP_PERIODS  = 16'd10;
    localparam logic [DUR_W-1:0] END_PAUSE_PERIODS = 16'd39;

    localparam logic [CFG_IDX_W-1:0] CFG_HIGH_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SHORT_LOW   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_LOW    = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD_TIME = 2'd3;

    localparam logic [TIME_W-1:0]   HIGH_TIME_RST   = 12'd250;
    localparam logic [TIME_W-1:0]   SHORT_LOW_RST   = 12'd250;
    localparam logic [TIME_W-1:0]   LONG_LOW_RST    = 12'd1250;
    localparam logic [PERIOD_W-1:0] PERIOD_TIME_RST = 10'd250;

    localparam logic MODE_TICK  = 1'b0;
    localparam logic MODE_START = 1'b1;

    typedef enum logic [2:0] {
        PH_IDLE      = 3'd0,
        PH_SYNC_HIGH = 3'd1,
        PH_SYNC_LOW  = 3'd2,
        PH_DATA_HIGH = 3'd3,
        PH_DATA_LOW  = 3'd4,
        PH_STOP_HIGH = 3'd5,
        PH_STOP_LOW  = 3'd6
    } phase_t;

    typedef struct packed {
        logic                    mode;
        logic [ID_FIELD_W-1:0]   transmitter_id;
        logic                    turn_on;
        logic [UNIT_FIELD_W-1:0] unit_number;
        logic [RC_W-1:0]         repeat_count;
    } in_item_t;

    typedef struct packed {
        logic pin_level;
        logic busy_res;
        logic frame_done;
    } out_item_t;

endpackage

@@ rtl/ook_remote_switch_frame_sender.sv @@
// ook remote switch frame sender: pulse-distance radio frame transmitter on microsecond ticks
// depends on ook_rsfs_pkg for payload structs, phase enum and constants
// each input transaction's result is registered in the output register in the cycle after it is accepted
// throughput: one input transaction per cycle while out_ready is high, set by the
// single state update between the state registers and the output register
// reset: asynchronous active low; line low, idle, registers at their default timings
`timescale 1ns / 1ps

module ook_remote_switch_frame_sender
    import ook_rsfs_pkg::*;
#(
    parameter int ID_BITS   = 26,
    parameter int UNIT_BITS = 4
)(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  in_item_t              in_data,
    output logic                  out_valid,
    input  logic                  out_ready,
    output out_item_t             out_data,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [TIME_W-1:0]     cfg_data
);

    localparam int FRAME_BITS = ID_BITS + 2 + UNIT_BITS;
    localparam int BIDX_W     = $clog2(FRAME_BITS + 1);
    localparam int POS_W      = $clog2(FRAME_BITS);

    // configuration
    logic [TIME_W-1:0]   high_time_reg;
    logic [TIME_W-1:0]   short_low_reg;
    logic [TIME_W-1:0]   long_low_reg;
    logic [PERIOD_W-1:0] period_time_reg;

    // transmit state
    logic [FRAME_BITS-1:0] frame_shift_reg,    frame_shift_next;
    logic [BIDX_W-1:0]     bit_index_reg,      bit_index_next;
    logic                  pair_half_reg,      pair_half_next;
    phase_t                phase_reg,          phase_next;
    logic [DUR_W-1:0]      duration_timer_reg, duration_timer_next;
    logic [RC_W-1:0]       repeats_left_reg,   repeats_left_next;
    logic                  line_level_reg,     line_level_next;
    logic                  sending_reg,        sending_next;

    out_item_t out_data_reg, out_data_next;
    logic      out_valid_reg;

    logic             accept;
    logic             load_en;
    logic             done;
    logic [POS_W-1:0] pos;
    logic             cur_bit;
    logic [DUR_W-1:0] load_dur;
    logic             load_level;

    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            high_time_reg   <= HIGH_TIME_RST;
            short_low_reg   <= SHORT_LOW_RST;
            long_low_reg    <= LONG_LOW_RST;
            period_time_reg <= PERIOD_TIME_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_HIGH_TIME:   high_time_reg   <= cfg_data;
                CFG_SHORT_LOW:   short_low_reg   <= cfg_data;
                CFG_LONG_LOW:    long_low_reg    <= cfg_data;
                CFG_PERIOD_TIME: period_time_reg <= cfg_data[PERIOD_W-1:0];
                default:         ;
            endcase
        end
    end

    // frame bit for the current pair half: inverse first, then the bit itself
    always_comb
    begin
        pos     = POS_W'(FRAME_BITS - 1) - bit_index_reg[POS_W-1:0];
        cur_bit = frame_shift_reg[pos] ^ ~pair_half_reg;
    end

    // next state
    always_comb
    begin
        frame_shift_next  = frame_shift_reg;
        bit_index_next    = bit_index_reg;
        pair_half_next    = pair_half_reg;
        phase_next        = phase_reg;
        repeats_left_next = repeats_left_reg;
        sending_next      = sending_reg;
        load_en           = 1'b0;
        done              = 1'b0;
        if (accept)
        begin
            if (in_data.mode == MODE_START)
            begin
                if (!sending_reg && (in_data.repeat_count != '0))
                begin
                    frame_shift_next  = {in_data.transmitter_id[ID_BITS-1:0], 1'b0,
                                         in_data.turn_on,
                                         in_data.unit_number[UNIT_BITS-1:0]};
                    repeats_left_next = in_data.repeat_count;
                    bit_index_next    = '0;
                    pair_half_next    = 1'b0;
                    sending_next      = 1'b1;
                    phase_next        = PH_SYNC_HIGH;
                    load_en           = 1'b1;
                end
            end
            else if (sending_reg && (duration_timer_reg <= DUR_W'(1)))
            begin
                load_en = 1'b1;
                case (phase_reg)
                    PH_SYNC_HIGH: phase_next = PH_SYNC_LOW;
                    PH_SYNC_LOW:
                    begin
                        bit_index_next = '0;
                        pair_half_next = 1'b0;
                        phase_next     = PH_DATA_HIGH;
                    end
                    PH_DATA_HIGH: phase_next = PH_DATA_LOW;
                    PH_DATA_LOW:
                    begin
                        if (!pair_half_reg)
                        begin
                            pair_half_next = 1'b1;
                            phase_next     = PH_DATA_HIGH;
                        end
                        else
                        begin
                            pair_half_next = 1'b0;
                            bit_index_next = bit_index_reg + 1'b1;
                            if (bit_index_next >= BIDX_W'(FRAME_BITS))
                                phase_next = PH_STOP_HIGH;
                            else
                                phase_next = PH_DATA_HIGH;
                        end
                    end
                    PH_STOP_HIGH: phase_next = PH_STOP_LOW;
                    PH_STOP_LOW:
                    begin
                        repeats_left_next = repeats_left_reg - 1'b1;
                        if (repeats_left_next != '0)
                            phase_next = PH_SYNC_HIGH;
                        else
                        begin
                            sending_next   = 1'b0;
                            bit_index_next = '0;
                            pair_half_next = 1'b0;
                            phase_next     = PH_IDLE;
                            done           = 1'b1;
                        end
                    end
                    default:
                    begin
                        sending_next = 1'b0;
                        phase_next   = PH_IDLE;
                    end
                endcase
            end
        end
    end

    // segment length and line level of the segment being loaded
    always_comb
    begin
        case (phase_next)
            PH_SYNC_HIGH, PH_DATA_HIGH, PH_STOP_HIGH:
            begin
                load_dur   = DUR_W'(high_time_reg);
                load_level = 1'b1;
            end
            PH_SYNC_LOW:
            begin
                load_dur   = DUR_W'(short_low_reg) +
                             DUR_W'(period_time_reg) * SYNC_GAP_PERIODS;
                load_level = 1'b0;
            end
            PH_DATA_LOW:
            begin
                load_dur   = cur_bit ? DUR_W'(short_low_reg) : DUR_W'(long_low_reg);
                load_level = 1'b0;
            end
            PH_STOP_LOW:
            begin
                load_dur   = DUR_W'(short_low_reg) +
                             DUR_W'(period_time_reg) * END_PAUSE_PERIODS;
                load_level = 1'b0;
            end
            default:
            begin
                load_dur   = '0;
                load_level = 1'b0;
            end
        endcase

        if (load_en)
        begin
            duration_timer_next = load_dur;
            line_level_next     = load_level;
        end
        else
        begin
            line_level_next = line_level_reg;
            if (accept && (in_data.mode == MODE_TICK) && sending_reg)
                duration_timer_next = duration_timer_reg - 1'b1;
            else
                duration_timer_next = duration_timer_reg;
        end
    end

    // result of the transaction shows the state after it
    always_comb
    begin
        out_data_next.pin_level  = line_level_next;
        out_data_next.busy_res   = sending_next;
        out_data_next.frame_done = done;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bit_index_reg      <= '0;
            pair_half_reg      <= 1'b0;
            phase_reg          <= PH_IDLE;
            duration_timer_reg <= '0;
            repeats_left_reg   <= '0;
            line_level_reg     <= 1'b0;
            sending_reg        <= 1'b0;
            out_valid_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                bit_index_reg      <= bit_index_next;
                pair_half_reg      <= pair_half_next;
                phase_reg          <= phase_next;
                duration_timer_reg <= duration_timer_next;
                repeats_left_reg   <= repeats_left_next;
                line_level_reg     <= line_level_next;
                sending_reg        <= sending_next;
                out_valid_reg      <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            frame_shift_reg <= frame_shift_next;
            out_data_reg    <= out_data_next;
        end
    end

endmodule

@@ sim/tb_top.sv @@
// testbench for ook_remote_switch_frame_sender: directed and random stimulus,
// line-level prediction per input transaction, result checking with random stalls
// depends on rtl/ook_rsfs_pkg.sv and rtl/ook_remote_switch_frame_sender.sv
`timescale 1ns / 1ps

module tb_top;
    import ook_rsfs_pkg::*;

    localparam int FRAME_W          = ID_FIELD_W + 2 + UNIT_FIELD_W;
    localparam int STALL_LIMIT      = 5000;
    localparam int MAX_REPORTS      = 10;
    localparam int RANDOM_PER_PHASE = 130;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_ready;
    in_item_t             in_data   = '0;
    logic                 out_valid;
    logic                 out_ready = 1'b0;
    out_item_t            out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [TIME_W-1:0]    cfg_data  = '0;

    // timing registers as the transmitter sees them
    logic [TIME_W-1:0]   high_us;
    logic [TIME_W-1:0]   short_us;
    logic [TIME_W-1:0]   long_us;
    logic [PERIOD_W-1:0] period_us;

    // transmitter state
    logic [FRAME_W-1:0] frame_bits;
    logic [5:0]         bit_pos;
    logic               second_half;
    phase_t             phase;
    logic [DUR_W-1:0]   seg_left;
    logic [RC_W-1:0]    repeats_left;
    logic               line_hi;
    logic               sending;

    out_item_t expected_line_q[$];
    out_item_t want;

    int items_sent     = 0;
    int frames_sent    = 0;
    int starts_dropped = 0;
    int results_seen   = 0;
    int fail_count     = 0;
    int quiet_cycles   = 0;
    int stall_odds     = 12;
    int gap_odds       = 12;

    ook_remote_switch_frame_sender u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    function automatic void reset_transmitter();
        high_us      = HIGH_TIME_RST;
        short_us     = SHORT_LOW_RST;
        long_us      = LONG_LOW_RST;
        period_us    = PERIOD_TIME_RST;
        frame_bits   = '0;
        bit_pos      = '0;
        second_half  = 1'b0;
        phase        = PH_IDLE;
        seg_left     = '0;
        repeats_left = '0;
        line_hi      = 1'b0;
        sending      = 1'b0;
    endfunction

    // each frame bit goes out inverted first, then as itself
    function automatic logic frame_bit_now();
        logic b;
        b = frame_bits[FRAME_W - 1 - bit_pos[4:0]];
        return second_half ? b : ~b;
    endfunction

    function automatic void load_segment(phase_t ph);
        int unsigned d;
        phase = ph;
        case (ph)
            PH_SYNC_HIGH, PH_DATA_HIGH, PH_STOP_HIGH:
            begin
                d = 32'(high_us);
                line_hi = 1'b1;
            end
            PH_SYNC_LOW:
            begin
                d = 32'(short_us) + 32'(SYNC_GAP_PERIODS) * 32'(period_us);
                line_hi = 1'b0;
            end
            PH_DATA_LOW:
            begin
                d = frame_bit_now() ? 32'(short_us) : 32'(long_us);
                line_hi = 1'b0;
            end
            PH_STOP_LOW:
            begin
                d = 32'(short_us) + 32'(END_PAUSE_PERIODS) * 32'(period_us);
                line_hi = 1'b0;
            end
            default:
            begin
                d = 0;
                line_hi = 1'b0;
            end
        endcase
        seg_left = d[DUR_W-1:0];
    endfunction

    // returns high when the last pause of the last repeat ends
    function automatic logic advance_segment();
        case (phase)
            PH_SYNC_HIGH: load_segment(PH_SYNC_LOW);
            PH_SYNC_LOW:
            begin
                bit_pos = '0;
                second_half = 1'b0;
                load_segment(PH_DATA_HIGH);
            end
            PH_DATA_HIGH: load_segment(PH_DATA_LOW);
            PH_DATA_LOW:
            begin
                if (!second_half)
                begin
                    second_half = 1'b1;
                    load_segment(PH_DATA_HIGH);
                end
                else
                begin
                    second_half = 1'b0;
                    bit_pos = bit_pos + 1'b1;
                    if (bit_pos >= FRAME_W)
                        load_segment(PH_STOP_HIGH);
                    else
                        load_segment(PH_DATA_HIGH);
                end
            end
            PH_STOP_HIGH: load_segment(PH_STOP_LOW);
            PH_STOP_LOW:
            begin
                frames_sent++;
                repeats_left = repeats_left - 1'b1;
                if (repeats_left != 0)
                    load_segment(PH_SYNC_HIGH);
                else
                begin
                    sending = 1'b0;
                    bit_pos = '0;
                    second_half = 1'b0;
                    load_segment(PH_IDLE);
                    return 1'b1;
                end
            end
            default:
            begin
                sending = 1'b0;
                load_segment(PH_IDLE);
            end
        endcase
        return 1'b0;
    endfunction

    function automatic out_item_t predict_line(in_item_t it);
        out_item_t r;
        logic done;
        done = 1'b0;
        if (it.mode == MODE_START)
        begin
            if (!sending && it.repeat_count != 0)
            begin
                frame_bits   = {it.transmitter_id, 1'b0, it.turn_on, it.unit_number};
                repeats_left = it.repeat_count;
                bit_pos      = '0;
                second_half  = 1'b0;
                sending      = 1'b1;
                load_segment(PH_SYNC_HIGH);
            end
            else
                starts_dropped++;
        end
        else if (sending)
        begin
            if (seg_left <= 1)
                done = advance_segment();
            else
                seg_left = seg_left - 1'b1;
        end
        r.pin_level  = line_hi;
        r.busy_res   = sending;
        r.frame_done = done;
        return r;
    endfunction

    function automatic in_item_t make_tick();
        in_item_t it;
        it.mode           = MODE_TICK;
        it.transmitter_id = ID_FIELD_W'($urandom);
        it.turn_on        = 1'($urandom);
        it.unit_number    = UNIT_FIELD_W'($urandom);
        it.repeat_count   = RC_W'($urandom);
        return it;
    endfunction

    function automatic in_item_t make_start(logic [ID_FIELD_W-1:0] id, logic on,
                                            logic [UNIT_FIELD_W-1:0] unit,
                                            logic [RC_W-1:0] rc);
        in_item_t it;
        it.mode           = MODE_START;
        it.transmitter_id = id;
        it.turn_on        = on;
        it.unit_number    = unit;
        it.repeat_count   = rc;
        return it;
    endfunction

    // leaves in_valid high so the next call can follow without a bubble
    task automatic send_item(in_item_t it);
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        expected_line_q.push_back(predict_line(it));
        items_sent++;
    endtask

    task automatic drain_outputs();
        in_valid <= 1'b0;
        while (expected_line_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_one(logic [CFG_IDX_W-1:0] idx, logic [TIME_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        case (idx)
            CFG_HIGH_TIME:   high_us   = value;
            CFG_SHORT_LOW:   short_us  = value;
            CFG_LONG_LOW:    long_us   = value;
            CFG_PERIOD_TIME: period_us = value[PERIOD_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_timing(logic [TIME_W-1:0] h, logic [TIME_W-1:0] s,
                              logic [TIME_W-1:0] l, logic [TIME_W-1:0] p);
        write_one(CFG_HIGH_TIME, h);
        write_one(CFG_SHORT_LOW, s);
        write_one(CFG_LONG_LOW, l);
        write_one(CFG_PERIOD_TIME, p);
        cfg_valid <= 1'b0;
    endtask

    task automatic run_until_idle();
        while (sending) send_item(make_tick());
    endtask

    task automatic test_idle_ticks();
        in_item_t it;
        repeat (3) send_item(make_tick());
        it = '1;
        it.repeat_count = '0;
        send_item(it);
        repeat (2) send_item(make_tick());
        drain_outputs();
    endtask

    // reset high time on the first sync pulse
    task automatic test_default_timing();
        send_item(make_start(26'h2F0A5C3, 1'b1, 4'h6, 8'd1));
        repeat (100) send_item(make_tick());
        drain_outputs();
    endtask

    // retune while busy: zero registers give one-tick segments from the next segment on
    task automatic test_zero_durations();
        set_timing('0, '0, 12'd2, '0);
        run_until_idle();
        drain_outputs();
    endtask

    task automatic test_field_extremes();
        // period write carries upper bits that the register drops
        set_timing(12'd1, '0, 12'd2, 12'h400);
        send_item(make_start('1, 1'b1, '1, 8'd1));
        // start while busy is dropped
        send_item(make_start('0, 1'b0, '0, '1));
        run_until_idle();
        drain_outputs();
    endtask

    task automatic test_random_traffic();
        in_item_t it;
        int counted;
        for (int p = 0; p < 4; p++)
        begin
            drain_outputs();
            set_timing(TIME_W'($urandom_range(0, 1)), TIME_W'($urandom_range(0, 1)),
                       TIME_W'($urandom_range(0, 2)), TIME_W'($urandom_range(0, 1)));
            case (p)
                0: begin stall_odds = 6;  gap_odds = 6;  end
                1: begin stall_odds = 20; gap_odds = 3;  end
                2: begin stall_odds = 3;  gap_odds = 25; end
                default: begin stall_odds = 0; gap_odds = 0; end
            endcase
            counted = 0;
            while (counted < RANDOM_PER_PHASE)
            begin
                it = make_tick();
                if (!sending)
                begin
                    if ($urandom_range(0, 9) < 7)
                    begin
                        it.mode = MODE_START;
                        it.repeat_count = ($urandom_range(0, 9) == 0) ?
                                          '0 : RC_W'($urandom_range(1, 3));
                    end
                end
                else if ($urandom_range(0, 24) == 0)
                    it.mode = MODE_START;
                if (it.mode == MODE_TICK ? sending : (!sending && it.repeat_count != 0))
                    counted++;
                send_item(it);
            end
        end
    endtask

    // result checker
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_line_q.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("unexpected result pin=%0b busy=%0b done=%0b",
                             out_data.pin_level, out_data.busy_res, out_data.frame_done);
            end
            else
            begin
                want = expected_line_q.pop_front();
                results_seen++;
                if (want.pin_level !== out_data.pin_level ||
                    want.busy_res !== out_data.busy_res ||
                    want.frame_done !== out_data.frame_done)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                        $display({"result %0d: expected pin=%0b busy=%0b done=%0b,",
                                  " got pin=%0b busy=%0b done=%0b"},
                                 results_seen, want.pin_level, want.busy_res,
                                 want.frame_done, out_data.pin_level,
                                 out_data.busy_res, out_data.frame_done);
                end
            end
        end
    end

    // receiver stalls in bursts
    initial
    begin
        int stall_left;
        stall_left = 0;
        forever
        begin
            @(posedge clk);
            if (stall_left > 0)
            begin
                out_ready <= 1'b0;
                stall_left--;
            end
            else if (stall_odds != 0 && $urandom_range(1, stall_odds) == 1)
            begin
                out_ready <= 1'b0;
                stall_left = $urandom_range(0, 8);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles with no transaction on any channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("ook_remote_switch_frame_sender test failed");
            $finish;
        end
    end

    initial
    begin
        reset_transmitter();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_ticks();
        test_default_timing();
        test_zero_durations();
        test_field_extremes();
        test_random_traffic();
        drain_outputs();
        if (expected_line_q.size() != 0)
            fail_count++;
        $display("run covered %0d input transactions, %0d frames on air, %0d starts dropped",
                 items_sent, frames_sent, starts_dropped);
        $display("%0d results compared, %0d failures", results_seen, fail_count);
        if (fail_count == 0)
            $display("ook_remote_switch_frame_sender test passed");
        else
            $display("ook_remote_switch_frame_sender test failed");
        $finish;
    end

endmodule

@@ files.f @@
rtl/ook_rsfs_pkg.sv
rtl/ook_remote_switch_frame_sender.sv
sim/tb_top.sv
